// ===== hw/rtl/midpoint_line_rasterizer_defines.svh =====
// ----------------------------------------------------------------------------
// midpoint line rasterizer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_LINE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_LINE_RASTERIZER_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define MLR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds, consequent holds in the following cycle
`define MLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// mlr_pkg
// types and constants for the midpoint line rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package mlr_pkg;

   localparam int COORD_BITS = 6;
   localparam int DEC_BITS   = COORD_BITS + 4;
   localparam int FIELD_BITS = 6;
   localparam int COLOR_BITS = 8;

   typedef struct packed {
      logic [FIELD_BITS-1:0] x_start;
      logic [FIELD_BITS-1:0] y_start;
      logic [FIELD_BITS-1:0] x_end;
      logic [FIELD_BITS-1:0] y_end;
      logic [COLOR_BITS-1:0] color_red;
      logic [COLOR_BITS-1:0] color_green;
      logic [COLOR_BITS-1:0] color_blue;
   } req_payload_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] pixel_x;
      logic [FIELD_BITS-1:0] pixel_y;
      logic [COLOR_BITS-1:0] pixel_red;
      logic [COLOR_BITS-1:0] pixel_green;
      logic [COLOR_BITS-1:0] pixel_blue;
      logic                  last_pixel;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_INIT,
      ST_RUN
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/midpoint_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// walks one line segment per request and emits its pixels in order
// ----------------------------------------------------------------------------
// req channel: one segment (two endpoints, colour) per request, valid/stall.
// rsp channel: one pixel per response with the colour and a last flag set on
// the final pixel of the segment.
// a request is taken only while the block is idle; req_stall stays high
// until the last pixel of the segment has been loaded into the output
// register. setup sorts the endpoints and forms the step terms, then
// computes the initial decision on the shared adder, after which the shared
// decision adder produces one pixel per cycle while rsp is not stalled.
// a segment spans 1 to 64 pixels; the next request may be accepted while
// the last pixel is still waiting in the output register.
// a stall on rsp holds the pixel and pauses the walk in place.
// reset is synchronous and returns the block to idle with no pixel pending.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_line_rasterizer
   import mlr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire req_payload_type req_payload,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      rsp_payload_type rsp_payload
);

   localparam int CW = COORD_BITS;
   localparam int DW = DEC_BITS;

   state_type state_ff, state_in;

   req_payload_type seg_ff;

   logic                 steep_ff;
   logic                 sig_neg_ff;
   logic [CW-1:0]        major_ff;
   logic [CW-1:0]        minor_ff;
   logic [CW-1:0]        endm_ff;
   logic signed [DW-1:0] half_ff;
   logic signed [DW-1:0] base_ff;
   logic signed [DW-1:0] add_step_ff;
   logic signed [DW-1:0] add_hold_ff;
   logic                 b_zero_ff;
   logic signed [DW-1:0] dec_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic accept;
   logic do_setup;
   logic do_init;
   logic emit;
   logic last;

   // setup datapath
   logic [CW-1:0]        sx1, sy1, sx2, sy2;
   logic [CW-1:0]        adx, ady;
   logic                 steep, swap;
   logic [CW-1:0]        p1x, p1y, p2x, p2y;
   logic                 sig_neg;
   logic signed [DW-1:0] a_val, b_val, sa_val, sb_val, v_val, v_adj, half_val;

   // shared decision adder
   logic signed [DW-1:0] add_a, add_b, add_sum;
   logic                 sd_pos, minor_steps;

   assign accept = req_valid && !req_stall;

   always_comb begin
      sx1 = seg_ff.x_start[CW-1:0];
      sy1 = seg_ff.y_start[CW-1:0];
      sx2 = seg_ff.x_end[CW-1:0];
      sy2 = seg_ff.y_end[CW-1:0];
      adx = (sx2 >= sx1) ? sx2 - sx1 : sx1 - sx2;
      ady = (sy2 >= sy1) ? sy2 - sy1 : sy1 - sy2;
      steep = !(ady < adx);
      swap = steep ? (sy2 < sy1) : (sx2 < sx1);
      p1x = swap ? sx2 : sx1;
      p1y = swap ? sy2 : sy1;
      p2x = swap ? sx1 : sx2;
      p2y = swap ? sy1 : sy2;
      sig_neg = steep ? !(p2x > p1x) : !(p2y > p1y);
      a_val = $signed(DW'(p2y)) - $signed(DW'(p1y));
      b_val = $signed(DW'(p1x)) - $signed(DW'(p2x));
      sa_val = sig_neg ? -a_val : a_val;
      sb_val = sig_neg ? -b_val : b_val;
      v_val = steep ? sa_val : sb_val;
      v_adj = v_val + $signed({{(DW-1){1'b0}}, v_val[DW-1]});
      half_val = v_adj >>> 1;
   end

   always_comb begin
      sd_pos = sig_neg_ff ? (dec_ff < 0) : (dec_ff > 0);
      minor_steps = steep_ff ? !sd_pos : sd_pos;
      last = (major_ff == endm_ff);
      add_a = (state_ff == ST_RUN) ? dec_ff : half_ff;
      if (state_ff == ST_RUN) begin
         add_b = minor_steps ? add_step_ff : add_hold_ff;
      end else begin
         add_b = base_ff;
      end
      add_sum = add_a + add_b;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_SETUP;
         ST_SETUP: state_in = ST_INIT;
         ST_INIT:  state_in = ST_RUN;
         ST_RUN:   if (emit && last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      do_setup = 1'b0;
      do_init = 1'b0;
      emit = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_SETUP: do_setup = 1'b1;
         ST_INIT:  do_init = 1'b1;
         ST_RUN:   emit = !rsp_valid_ff || !rsp_stall;
         default:  req_stall = 1'b1;
      endcase
   end

   always_comb begin
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_payload_in = rsp_payload_ff;
      if (emit) begin
         rsp_payload_in.pixel_x = steep_ff ? FIELD_BITS'(minor_ff) : FIELD_BITS'(major_ff);
         rsp_payload_in.pixel_y = steep_ff ? FIELD_BITS'(major_ff) : FIELD_BITS'(minor_ff);
         rsp_payload_in.pixel_red = seg_ff.color_red;
         rsp_payload_in.pixel_green = seg_ff.color_green;
         rsp_payload_in.pixel_blue = seg_ff.color_blue;
         rsp_payload_in.last_pixel = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (accept) begin
         seg_ff <= req_payload;
      end
      if (do_setup) begin
         steep_ff <= steep;
         sig_neg_ff <= sig_neg;
         major_ff <= steep ? p1y : p1x;
         minor_ff <= steep ? p1x : p1y;
         endm_ff <= steep ? p2y : p2x;
         half_ff <= half_val;
         base_ff <= steep ? b_val : a_val;
         add_step_ff <= steep ? sa_val + b_val : a_val + sb_val;
         add_hold_ff <= steep ? b_val : a_val;
         b_zero_ff <= (b_val == '0);
      end
      if (do_init) begin
         // vertical segment keeps its column
         if (steep_ff && b_zero_ff && add_sum == '0) begin
            dec_ff <= '1;
         end else begin
            dec_ff <= add_sum;
         end
      end
      if (emit) begin
         dec_ff <= add_sum;
         major_ff <= major_ff + 1'b1;
         if (minor_steps) begin
            minor_ff <= sig_neg_ff ? minor_ff - 1'b1 : minor_ff + 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mlr_checker.sv =====
// ----------------------------------------------------------------------------
// mlr_checker
// port-level checks on the midpoint line rasterizer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "midpoint_line_rasterizer_defines.svh"

module mlr_checker
   import mlr_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_payload
);

   `MLR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled pixel changed")
   `MLR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "request taken while a segment is in flight")
   `MLR_ASSERT_NOW(a_idle_only_last, clock, reset, rsp_valid && !req_stall, rsp_payload.last_pixel, "idle with a pixel other than the last pending")
   `MLR_ASSERT_NEXT(a_walk_continues, clock, reset, rsp_valid && !rsp_stall && !rsp_payload.last_pixel, rsp_valid, "segment ended without a last pixel")

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (.*);

`default_nettype wire
